@@ rtl/cfrg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cfrg_pkg;

  // width of modulus, convergent and residue values
  localparam int RW = 31;
  localparam int NUM_PRIMES = 62;
  localparam int PIDX_W = 6;

  typedef logic [8:0] prime_t;

  // primes of the factor base, in ascending order
  localparam prime_t PRIME_TAB [NUM_PRIMES] = '{
    9'd2, 9'd3, 9'd5, 9'd7, 9'd11, 9'd13, 9'd17, 9'd19, 9'd23, 9'd29, 9'd31,
    9'd37, 9'd41, 9'd43, 9'd47, 9'd53, 9'd59, 9'd61, 9'd67, 9'd71, 9'd73,
    9'd79, 9'd83, 9'd89, 9'd97, 9'd101, 9'd103, 9'd107, 9'd109, 9'd113,
    9'd127, 9'd131, 9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167,
    9'd173, 9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263, 9'd269,
    9'd271, 9'd277, 9'd281, 9'd283, 9'd293
  };

  localparam logic signed [9:0] SIGN_ELEM = -10'sd1;

  // number of table primes not above the bound
  function automatic int count_primes(input int bound);
    int c;
    c = 0;
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (int'(PRIME_TAB[i]) <= bound) c = c + 1;
    end
    return c;
  endfunction

  // one queued command from the front part
  typedef struct packed {
    logic restart;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/cfrg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface cfrg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface cfrg_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        step_index;
  logic [16:0]        partial_quotient;
  logic [30:0]        convergent_mod;
  logic signed [30:0] signed_residue;
  logic signed [9:0]  base_element;
  logic [4:0]         multiplicity;
  logic               last;
  modport source (output valid, output step_index, output partial_quotient,
                  output convergent_mod, output signed_residue, output base_element,
                  output multiplicity, output last, input ready);
  modport sink (input valid, input step_index, input partial_quotient,
                input convergent_mod, input signed_residue, input base_element,
                input multiplicity, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/cfrg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cfrg_front
  import cfrg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  cfrg_in_if.sink    in_ch,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_take
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       started_r;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = cmd_take && (cnt_r != 2'd0);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  // queue of classified commands; first transaction always restarts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      started_r <= 1'b0;
    end else begin
      if (push) begin
        q_r[wp_r].restart <= in_ch.restart || !started_r;
        wp_r <= !wp_r;
        started_r <= 1'b1;
      end
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/cfrg_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cfrg_engine
  import cfrg_pkg::*;
#(
  parameter int NP = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [RW-1:0] n,
  input  wire cmd_t          cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_take,
  cfrg_out_if.source         out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_DIV, S_RED1, S_RED2, S_MUL, S_ADD, S_SQ, S_RES, S_OUT, S_TDIV
  } state_t;

  state_t             state_r;
  logic [15:0]        root_r;
  logic [16:0]        u_r;
  logic signed [30:0] pr_r;
  logic [30:0]        p1_r, p2_r, p_r, p2red_r;
  logic [15:0]        step_r;
  logic [16:0]        a_r;
  logic [30:0]        v_r, mag_r;
  logic [4:0]         cnt_r;
  logic [30:0]        acc_r, mx_r, mm_m_r;
  logic [30:0]        div_rem_r;
  logic [17:0]        div_d_r;
  logic [PIDX_W-1:0]  pidx_r;
  logic [4:0]         exp_r;
  logic [30:0]        tx_r;
  logic [8:0]         trem_r;
  logic               ov_r, olast_r;
  logic signed [9:0]  oelem_r;
  logic [4:0]         omult_r;

  // integer square root, one bit per cycle
  logic [15:0] trial;
  logic [31:0] trial_sq;
  logic        trial_ok;
  logic [15:0] root_fin;
  assign trial = root_r | (16'd1 << cnt_r[3:0]);
  assign trial_sq = trial * trial;
  assign trial_ok = trial_sq <= {1'b0, n};
  assign root_fin = trial_ok ? trial : root_r;

  // shared modular multiply step: acc = 2*acc + bit*m mod n
  logic [31:0] x2, x2r, y, yr;
  logic [30:0] mm_y;
  assign x2  = {acc_r, 1'b0};
  assign x2r = (x2 >= {1'b0, n}) ? x2 - {1'b0, n} : x2;
  assign y   = x2r + (mx_r[30] ? {1'b0, mm_m_r} : 32'd0);
  assign yr  = (y >= {1'b0, n}) ? y - {1'b0, n} : y;
  assign mm_y = yr[30:0];

  // restoring division for the partial quotient
  logic [31:0] dsh;
  logic        dge;
  logic [17:0] dq;
  assign dsh = {div_rem_r, div_d_r[17]};
  assign dge = dsh >= {1'b0, v_r};
  assign dq = {div_d_r[16:0], dge};

  // trial division by the current prime
  prime_t      q;
  logic [9:0]  tsh, trem_n;
  logic        tge;
  assign q = PRIME_TAB[pidx_r];
  assign tsh = {trem_r, tx_r[30]};
  assign tge = tsh >= {1'b0, q};
  assign trem_n = tge ? tsh - {1'b0, q} : tsh;

  // next offset and convergent
  logic [33:0] uprod;
  logic [16:0] u_nxt;
  logic [31:0] psum;
  logic [30:0] p_nxt;
  assign uprod = a_r * v_r[16:0];
  assign u_nxt = uprod[16:0] - u_r;
  assign psum = {1'b0, acc_r} + {1'b0, p2red_r};
  assign p_nxt = (psum >= {1'b0, n}) ? 31'(psum - {1'b0, n}) : psum[30:0];

  // residue into symmetric range
  logic        res_neg;
  logic [31:0] neg_r;
  logic [30:0] v_abs;
  assign res_neg = acc_r > (n >> 1);
  assign neg_r = {1'b0, acc_r} - {1'b0, n};
  assign v_abs = pr_r[30] ? 31'(-pr_r) : 31'(pr_r);

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  assign out_ch.valid = ov_r;
  assign out_ch.step_index = step_r;
  assign out_ch.partial_quotient = a_r;
  assign out_ch.convergent_mod = p_r;
  assign out_ch.signed_residue = pr_r;
  assign out_ch.base_element = oelem_r;
  assign out_ch.multiplicity = omult_r;
  assign out_ch.last = olast_r;

  // step sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      root_r <= '0;
      u_r <= '0;
      pr_r <= '0;
      p1_r <= '0;
      p2_r <= 31'd1;
      step_r <= '0;
      ov_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.restart) begin
              root_r <= '0;
              cnt_r <= 5'd15;
              state_r <= S_ROOT;
            end else begin
              v_r <= v_abs;
              if (step_r != 16'hFFFF) step_r <= step_r + 16'd1;
              if (v_abs == '0) begin
                a_r <= '0;
                acc_r <= '0;
                mx_r <= p1_r;
                mm_m_r <= 31'd1;
                cnt_r <= 5'd30;
                state_r <= S_RED1;
              end else begin
                div_d_r <= {2'b00, root_r} + {1'b0, u_r};
                div_rem_r <= '0;
                cnt_r <= 5'd17;
                state_r <= S_DIV;
              end
            end
          end
        end
        S_ROOT: begin
          root_r <= root_fin;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            a_r <= {1'b0, root_fin};
            u_r <= {1'b0, root_fin};
            p_r <= {15'd0, root_fin};
            p1_r <= {15'd0, root_fin};
            p2_r <= 31'd1;
            step_r <= '0;
            acc_r <= '0;
            mx_r <= {15'd0, root_fin};
            mm_m_r <= {15'd0, root_fin};
            cnt_r <= 5'd30;
            state_r <= S_SQ;
          end
        end
        S_DIV: begin
          div_rem_r <= dge ? 31'(dsh - {1'b0, v_r}) : dsh[30:0];
          div_d_r <= dq;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            a_r <= dq[17] ? 17'h1FFFF : dq[16:0];
            acc_r <= '0;
            mx_r <= p1_r;
            mm_m_r <= 31'd1;
            cnt_r <= 5'd30;
            state_r <= S_RED1;
          end
        end
        S_RED1: begin
          acc_r <= mm_y;
          mx_r <= {mx_r[29:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            p_r <= mm_y;
            acc_r <= '0;
            mx_r <= p2_r;
            cnt_r <= 5'd30;
            state_r <= S_RED2;
          end
        end
        S_RED2: begin
          acc_r <= mm_y;
          mx_r <= {mx_r[29:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            p2red_r <= mm_y;
            acc_r <= '0;
            mm_m_r <= p_r;
            mx_r <= {a_r, 14'd0};
            cnt_r <= 5'd16;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= mm_y;
          mx_r <= {mx_r[29:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= S_ADD;
        end
        S_ADD: begin
          p_r <= p_nxt;
          p2_r <= p1_r;
          p1_r <= p_nxt;
          u_r <= u_nxt;
          acc_r <= '0;
          mx_r <= p_nxt;
          mm_m_r <= p_nxt;
          cnt_r <= 5'd30;
          state_r <= S_SQ;
        end
        S_SQ: begin
          acc_r <= mm_y;
          mx_r <= {mx_r[29:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= S_RES;
        end
        S_RES: begin
          if (res_neg) begin
            pr_r <= neg_r[30:0];
            mag_r <= 31'(n - acc_r);
          end else begin
            pr_r <= acc_r;
            mag_r <= acc_r;
          end
          oelem_r <= SIGN_ELEM;
          omult_r <= {4'd0, res_neg};
          olast_r <= (NP == 0);
          ov_r <= 1'b1;
          pidx_r <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            ov_r <= 1'b0;
            if (olast_r) begin
              state_r <= S_IDLE;
            end else if (mag_r == '0) begin
              oelem_r <= {1'b0, q};
              omult_r <= '0;
              olast_r <= (pidx_r == PIDX_W'(NP - 1));
              pidx_r <= pidx_r + 1'b1;
              ov_r <= 1'b1;
            end else begin
              exp_r <= '0;
              tx_r <= mag_r;
              trem_r <= '0;
              cnt_r <= 5'd30;
              state_r <= S_TDIV;
            end
          end
        end
        S_TDIV: begin
          trem_r <= trem_n[8:0];
          tx_r <= {tx_r[29:0], tge};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            if (trem_n == '0) begin
              // divisible: keep quotient and try again
              if (exp_r != 5'd31) exp_r <= exp_r + 5'd1;
              trem_r <= '0;
              cnt_r <= 5'd30;
            end else begin
              oelem_r <= {1'b0, q};
              omult_r <= exp_r;
              olast_r <= (pidx_r == PIDX_W'(NP - 1));
              pidx_r <= pidx_r + 1'b1;
              ov_r <= 1'b1;
              state_r <= S_OUT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/cfrac_relation_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Continued-fraction relation generator for sqrt(modulus). Each input transaction
// yields one expansion step and then one result per factor-base element (-1 first,
// then the primes up to FACTOR_BASE_BOUND, the last one flagged). Items are taken
// into a two-entry queue while it has room; the step engine works on one at a time.
// A restart step takes the square root and then the modular square; an advance
// step runs the quotient division, then the modular reductions and products in the
// one shared multiply-mod unit, skipping the division when the divisor is zero. Each
// prime is then run through the bit-serial trial divider once per factor found and
// once more, and then handed out; with a zero residue the trial divider is skipped.
module cfrac_relation_generator
  import cfrg_pkg::*;
#(
  parameter int FACTOR_BASE_BOUND = 30,
  parameter int MODULUS_WIDTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [MODULUS_WIDTH-1:0] cfg_wdata,
  cfrg_in_if.sink                       in_chan,
  cfrg_out_if.source                    out_chan
);

  localparam int NP = count_primes(FACTOR_BASE_BOUND);

  logic [MODULUS_WIDTH-1:0] mod_r;
  logic [RW-1:0]            mod_ext, n;
  cmd_t                     cmd;
  logic                     cmd_valid, cmd_take;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_WIDTH'(2);
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  assign mod_ext = RW'(mod_r);
  assign n = (mod_ext < RW'(2)) ? RW'(2) : mod_ext;

  cfrg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  cfrg_engine #(.NP(NP)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .out_ch    (out_chan)
  );

`ifndef SYNTHESIS
  // sign element reports the sign of the residue
  a_sign_mult: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.base_element == SIGN_ELEM) |->
      (out_chan.multiplicity == {4'd0, out_chan.signed_residue[30]}))
    else $error("sign exponent does not match residue");

  // zero residue gives zero prime exponents
  a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.signed_residue == '0) |->
      (out_chan.multiplicity == '0))
    else $error("nonzero exponent on zero residue");

  // step engine takes no command while a result is waiting
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !cmd_take)
    else $error("command taken while result pending");
`endif

endmodule
`default_nettype wire

@@ dv/cfrac_relation_generator_tb.sv @@
`timescale 1ns / 1ps
module cfrac_relation_generator_tb;
  import cfrg_pkg::*;

  localparam int BASE_BOUND = 30;
  localparam int STALL_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 50;

  // one relation result as seen on the output channel
  typedef struct {
    logic [15:0]        step;
    logic [16:0]        quotient;
    logic [30:0]        conv;
    logic signed [30:0] residue;
    logic signed [9:0]  elem;
    logic [4:0]         mult;
    logic               last;
  } relation_t;

  // directed stimulus row; step, quotient, conv and residue typed in when known
  typedef struct {
    bit          set_modulus;
    bit [30:0]   modulus_val;
    bit          restart;
    bit          typed;
    logic [15:0] step;
    logic [16:0] quotient;
    logic [30:0] conv;
    int          residue;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  cfrg_in_if in_bus ();
  cfrg_out_if out_bus ();

  cfrac_relation_generator uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan(in_bus),
    .out_chan(out_bus)
  );

  always #4 clk = ~clk;

  // expansion state mirrored from the block
  bit [30:0]       modulus_reg = 31'd2;
  longint unsigned root_val = 0;
  longint unsigned offset_val = 0;
  longint          residue_prev = 0;
  longint unsigned conv_p1 = 0;
  longint unsigned conv_p2 = 1;
  longint unsigned step_num = 0;
  bit              expansion_live = 1'b0;

  relation_t pending_relations[$];
  int error_count = 0;
  int items_sent = 0;
  int relations_seen = 0;
  int moduli_used = 1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned isqrt_floor(longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 65536;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic int prime_power(longint unsigned mag, longint unsigned q);
    int e;
    e = 0;
    if (mag == 0) return 0;
    while (mag % q == 0) begin
      mag = mag / q;
      e++;
    end
    return (e > 31) ? 31 : e;
  endfunction

  // advance the mirrored expansion by one step and queue its relations
  task automatic predict_relations(input bit restart, input bit typed, input stim_row_t row);
    longint unsigned n, a, u, p, v, sq, mag;
    longint r;
    relation_t rel;
    n = (modulus_reg < 2) ? 2 : modulus_reg;
    if (!expansion_live || restart) begin
      root_val = isqrt_floor(n);
      a = root_val;
      u = a;
      p = a % n;
      conv_p2 = 1;
      step_num = 0;
      expansion_live = 1'b1;
    end else begin
      v = (residue_prev < 0) ? longint'(-residue_prev) : residue_prev;
      if (v == 0) a = 0;
      else begin
        a = (root_val + offset_val) / v;
        if (a > 131071) a = 131071;
      end
      u = (a * v - offset_val) & 64'h1FFFF;
      p = (a * conv_p1 + conv_p2) % n;
      conv_p2 = conv_p1;
      if (step_num < 65535) step_num++;
    end
    conv_p1 = p;
    offset_val = u;
    sq = (p * p) % n;
    r = sq;
    if (sq > n / 2) r = longint'(sq) - longint'(n);
    residue_prev = r;
    mag = (r < 0) ? longint'(-r) : r;

    rel.step = step_num[15:0];
    rel.quotient = a[16:0];
    rel.conv = p[30:0];
    rel.residue = r[30:0];
    if (typed) begin
      rel.step = row.step;
      rel.quotient = row.quotient;
      rel.conv = row.conv;
      rel.residue = row.residue[30:0];
    end
    // sign element first, then every prime up to the bound
    rel.elem = SIGN_ELEM;
    rel.mult = (r < 0) ? 5'd1 : 5'd0;
    rel.last = (count_primes(BASE_BOUND) == 0);
    pending_relations = {pending_relations, rel};
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (int'(PRIME_TAB[i]) <= BASE_BOUND) begin
        rel.elem = $signed({1'b0, PRIME_TAB[i]});
        rel.mult = 5'(prime_power(mag, PRIME_TAB[i]));
        rel.last = (i == count_primes(BASE_BOUND) - 1);
        pending_relations = {pending_relations, rel};
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // receiver side: random stalls per phase
  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // check each result transaction against the oldest expectation
  always @(posedge clk) begin
    relation_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      relations_seen++;
      if (pending_relations.size() == 0) begin
        $display("unexpected relation at %0t: element %0d", $realtime, out_bus.base_element);
        error_count++;
      end else begin
        want = pending_relations.pop_front();
        if (out_bus.step_index !== want.step)
          report_mismatch("step_index", out_bus.step_index, want.step);
        if (out_bus.partial_quotient !== want.quotient)
          report_mismatch("partial_quotient", out_bus.partial_quotient, want.quotient);
        if (out_bus.convergent_mod !== want.conv)
          report_mismatch("convergent_mod", out_bus.convergent_mod, want.conv);
        if (out_bus.signed_residue !== want.residue)
          report_mismatch("signed_residue", out_bus.signed_residue, want.residue);
        if (out_bus.base_element !== want.elem)
          report_mismatch("base_element", out_bus.base_element, want.elem);
        if (out_bus.multiplicity !== want.mult)
          report_mismatch("multiplicity", out_bus.multiplicity, want.mult);
        if (out_bus.last !== want.last)
          report_mismatch("last", out_bus.last, want.last);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_step(input bit restart, input bit typed, input stim_row_t row);
    @(negedge clk);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.restart = restart;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    predict_relations(restart, typed, row);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_relations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input bit [30:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    modulus_reg = value;
    moduli_used++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic bit [30:0] pick_modulus();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 64));
      1: return 31'($urandom_range(65, 100000));
      2: return 31'h7FFFFFFF;
      default: return 31'($urandom);
    endcase
  endfunction

  stim_row_t directed[22];
  stim_row_t blank_row;

  initial begin
    bit rs;
    in_bus.valid = 1'b0;
    in_bus.restart = 1'b0;
    out_bus.ready = 1'b0;
    blank_row = '{0, 0, 0, 0, 0, 0, 0, 0};
    directed = '{
      '{0, 0, 0, 1, 0, 1, 1, 1},             // first item after reset, no restart
      '{0, 0, 0, 1, 1, 2, 1, 1},
      '{1, 0, 1, 1, 0, 1, 1, 1},             // modulus zero treated as two
      '{1, 1, 1, 1, 0, 1, 1, 1},
      '{1, 2, 1, 1, 0, 1, 1, 1},
      '{1, 31'h7FFFFFFF, 1, 1, 0, 46340, 46340, -88047},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 4, 1, 1, 0, 2, 2, 0},             // zero residue
      '{0, 0, 0, 1, 1, 0, 1, 1},             // zero divisor after zero residue
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 1000003, 1, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 999983, 0, 0, 0, 0, 0, 0},        // modulus changed mid expansion
      '{1, 31'h55555555, 1, 0, 0, 0, 0, 0},
      '{1, 31'h2AAAAAAA, 1, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (directed[i]) begin
      if (directed[i].set_modulus) write_modulus(directed[i].modulus_val);
      send_step(directed[i].restart, directed[i].typed, directed[i]);
    end

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      write_modulus(pick_modulus());
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2) begin
          if (ph == 1) wait_drained();
          else if ($urandom_range(0, 1) == 1) write_modulus(pick_modulus());
        end
        rs = (k == 0) || ($urandom_range(0, 11) == 0);
        send_step(rs, 1'b0, blank_row);
      end
    end

    // drain and let the block settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d expansion steps over %0d modulus settings, %0d relations checked",
             items_sent, moduli_used, relations_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ cfrac_relation_generator.f @@
rtl/cfrg_pkg.sv
rtl/cfrg_if.sv
rtl/cfrg_front.sv
rtl/cfrg_engine.sv
rtl/cfrac_relation_generator.sv
dv/cfrac_relation_generator_tb.sv
